// File: rtl/assert_macros.svh
// Assertion macros used by the sequencer RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SDSPI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define SDSPI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SDSPI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SDSPI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/sdspi_pkg.sv
// Package for the SPI-mode card sequencer: field widths, codes and sizes.
// No dependencies.
`default_nettype none
package sdspi_pkg;

    localparam int BLOCK_BYTES = 512;

    localparam int FUNC_W    = 2;
    localparam int BLK_W     = 23;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_XFER = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RST_TMO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CMD_ERR  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_TOKEN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_CNT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LIMIT = 8'd3;

    typedef struct packed {
        logic                tx_valid;
        logic [BYTE_W-1:0]   tx_byte;
        logic                cs_active;
        logic                fast_clock;
        logic                data_valid;
        logic [BYTE_W-1:0]   data_byte;
        logic                last_data;
        logic                done_res;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/sdspi_if.sv
// Channel interfaces of the card sequencer: request, result and register write.
// Depends on sdspi_pkg.
`default_nettype none
interface sdspi_in_if;
    logic                           valid;
    logic                           ready;
    logic [sdspi_pkg::FUNC_W-1:0]   func;
    logic [sdspi_pkg::BLK_W-1:0]    block_addr;
    logic [sdspi_pkg::BYTE_W-1:0]   rx_byte;
    modport source (output valid, func, block_addr, rx_byte, input ready);
    modport sink   (input valid, func, block_addr, rx_byte, output ready);
endinterface

interface sdspi_out_if;
    logic                           valid;
    logic                           ready;
    logic                           tx_valid;
    logic [sdspi_pkg::BYTE_W-1:0]   tx_byte;
    logic                           cs_active;
    logic                           fast_clock;
    logic                           data_valid;
    logic [sdspi_pkg::BYTE_W-1:0]   data_byte;
    logic                           last_data;
    logic                           done_res;
    logic [sdspi_pkg::STATUS_W-1:0] status;
    modport source (output valid, tx_valid, tx_byte, cs_active, fast_clock, data_valid,
                    data_byte, last_data, done_res, status, input ready);
    modport sink   (input valid, tx_valid, tx_byte, cs_active, fast_clock, data_valid,
                    data_byte, last_data, done_res, status, output ready);
endinterface

interface sdspi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sdspi_pkg::CFG_IDX_W-1:0] reg_index;
    logic [sdspi_pkg::BYTE_W-1:0]    wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// File: rtl/sd_spi_init_and_block_read.sv
// SPI-mode card host sequencer: init (wake bytes, CMD0, CMD1) and single-block read.
// Depends on sdspi_pkg, sdspi_if.sv and assert_macros.svh.
//
// Every request item (start init, start read, or the byte received for the last byte
// sent) yields exactly one result item, registered in the cycle after the transaction.
// The decision is made combinationally between the request and the result register,
// so a new item is taken in every cycle while the result side keeps up; the output
// register is the only thing that can hold the request side back. In a system one item
// arrives per SPI byte exchange. Each result says whether another byte must be clocked
// out, which byte, the select and clock-speed levels, any block data byte and completion
// status. Register writes are always taken.
`default_nettype none
`include "assert_macros.svh"
module sd_spi_init_and_block_read (
    input  wire          i_clk,
    input  wire          i_rst_n,
    sdspi_in_if.sink     i_in,
    sdspi_out_if.source  o_out,
    sdspi_cfg_if.sink    i_cfg
);

    localparam int BC_RAW = $clog2(sdspi_pkg::BLOCK_BYTES + 1);
    localparam int BC_W   = (BC_RAW > 8) ? BC_RAW : 8;
    localparam logic [BC_W-1:0] BLOCK_LEN = BC_W'(sdspi_pkg::BLOCK_BYTES);

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_WAKE       = 4'd1;
    localparam logic [3:0] PH_DUMMY      = 4'd2;
    localparam logic [3:0] PH_FRAME      = 4'd3;
    localparam logic [3:0] PH_POLL       = 4'd4;
    localparam logic [3:0] PH_CMD0_TRAIL = 4'd5;
    localparam logic [3:0] PH_CMD1_TRAIL = 4'd6;
    localparam logic [3:0] PH_TOKEN      = 4'd7;
    localparam logic [3:0] PH_DATA       = 4'd8;
    localparam logic [3:0] PH_CRC        = 4'd9;

    localparam logic [7:0] OP_CMD0  = 8'h40;
    localparam logic [7:0] OP_CMD1  = 8'h41;
    localparam logic [7:0] OP_CMD17 = 8'h51;
    localparam logic [7:0] FILL     = 8'hFF;
    localparam logic [7:0] TOKEN    = 8'hFE;
    localparam logic [7:0] CRC_CMD0 = 8'h95;
    localparam logic [7:0] R1_IDLE  = 8'h01;
    localparam logic [2:0] FRAME_LEN = 3'd6;

    // registers
    logic [7:0]      r_wake_cnt, r_retry_limit, r_poll_limit, r_token_limit;
    logic [3:0]      r_phase, n_phase;
    logic [BC_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [7:0]      r_retry, n_retry;
    logic [7:0]      r_poll, n_poll;
    logic [2:0]      r_frame_idx, n_frame_idx;
    logic [7:0]      r_cmd_op, n_cmd_op;
    logic [23:0]     r_cmd_addr, n_cmd_addr;
    logic            r_crc_set, n_crc_set;
    logic [7:0]      r_last_resp, n_last_resp;
    logic            r_speed, n_speed;
    logic            r_sel, n_sel;
    logic            r_out_valid;
    sdspi_pkg::t_result r_out, n_out;

    logic            w_in_acc;
    logic [2:0]      w_idx_inc;
    logic [7:0]      w_frame_byte;
    logic [7:0]      w_poll_inc;
    logic [BC_W-1:0] w_bc_inc;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign w_idx_inc  = r_frame_idx + 3'd1;
    assign w_poll_inc = (r_poll == 8'hFF) ? r_poll : r_poll + 8'd1;
    assign w_bc_inc   = r_byte_cnt + BC_W'(1);

    always_comb begin
        unique case (w_idx_inc)
            3'd1:    w_frame_byte = r_cmd_addr[23:16];
            3'd2:    w_frame_byte = r_cmd_addr[15:8];
            3'd3:    w_frame_byte = r_cmd_addr[7:0];
            3'd5:    w_frame_byte = r_crc_set ? CRC_CMD0 : 8'h00;
            default: w_frame_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_byte_cnt  = r_byte_cnt;
        n_retry     = r_retry;
        n_poll      = r_poll;
        n_frame_idx = r_frame_idx;
        n_cmd_op    = r_cmd_op;
        n_cmd_addr  = r_cmd_addr;
        n_crc_set   = r_crc_set;
        n_last_resp = r_last_resp;
        n_speed     = r_speed;
        n_sel       = r_sel;
        n_out       = '0;
        if (w_in_acc) begin
            unique case (i_in.func)
                sdspi_pkg::FUNC_INIT: begin
                    n_speed    = 1'b0;
                    n_sel      = 1'b0;
                    n_cmd_op   = OP_CMD0;
                    n_cmd_addr = '0;
                    n_crc_set  = 1'b1;
                    n_retry    = '0;
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = FILL;
                    if (r_wake_cnt == 8'd0) begin
                        n_phase = PH_DUMMY;
                    end else begin
                        n_phase    = PH_WAKE;
                        n_byte_cnt = BC_W'(1);
                    end
                end
                sdspi_pkg::FUNC_READ: begin
                    n_speed    = 1'b1;
                    n_cmd_op   = OP_CMD17;
                    n_cmd_addr = {i_in.block_addr, 1'b0};
                    n_phase    = PH_DUMMY;
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = FILL;
                end
                sdspi_pkg::FUNC_XFER: begin
                    unique case (r_phase)
                        PH_WAKE: begin
                            n_out.tx_valid = 1'b1;
                            n_out.tx_byte  = FILL;
                            if (r_byte_cnt >= BC_W'(r_wake_cnt)) begin
                                n_phase = PH_DUMMY;
                            end else begin
                                n_byte_cnt = w_bc_inc;
                            end
                        end
                        PH_DUMMY: begin
                            n_sel       = 1'b1;
                            n_frame_idx = '0;
                            n_phase     = PH_FRAME;
                            n_out.tx_valid = 1'b1;
                            n_out.tx_byte  = r_cmd_op;
                        end
                        PH_FRAME: begin
                            n_frame_idx    = w_idx_inc;
                            n_out.tx_valid = 1'b1;
                            if (w_idx_inc < FRAME_LEN) begin
                                n_out.tx_byte = w_frame_byte;
                            end else begin
                                n_phase       = PH_POLL;
                                n_poll        = '0;
                                n_out.tx_byte = FILL;
                            end
                        end
                        PH_POLL: begin
                            n_poll = w_poll_inc;
                            if (!i_in.rx_byte[7] || w_poll_inc >= r_poll_limit) begin
                                // reply in hand or poll limit reached: act on the command just sent
                                n_last_resp = i_in.rx_byte;
                                if (r_cmd_op == OP_CMD0) begin
                                    if (r_retry != 8'hFF) n_retry = r_retry + 8'd1;
                                    n_sel   = 1'b0;
                                    n_phase = PH_CMD0_TRAIL;
                                    n_out.tx_valid = 1'b1;
                                    n_out.tx_byte  = FILL;
                                end else if (r_cmd_op == OP_CMD1) begin
                                    if (i_in.rx_byte == 8'h00) begin
                                        n_phase        = PH_IDLE;
                                        n_out.done_res = 1'b1;
                                        n_out.status   = sdspi_pkg::ST_OK;
                                    end else begin
                                        n_sel   = 1'b0;
                                        n_phase = PH_CMD1_TRAIL;
                                        n_out.tx_valid = 1'b1;
                                        n_out.tx_byte  = FILL;
                                    end
                                end else begin
                                    if (i_in.rx_byte != 8'h00) begin
                                        n_sel          = 1'b0;
                                        n_phase        = PH_IDLE;
                                        n_out.done_res = 1'b1;
                                        n_out.status   = sdspi_pkg::ST_CMD_ERR;
                                    end else begin
                                        n_phase = PH_TOKEN;
                                        n_poll  = '0;
                                        n_out.tx_valid = 1'b1;
                                        n_out.tx_byte  = FILL;
                                    end
                                end
                            end else begin
                                n_out.tx_valid = 1'b1;
                                n_out.tx_byte  = FILL;
                            end
                        end
                        PH_CMD0_TRAIL: begin
                            if (r_last_resp == R1_IDLE) begin
                                n_cmd_op = OP_CMD1;
                                n_phase  = PH_DUMMY;
                                n_out.tx_valid = 1'b1;
                                n_out.tx_byte  = FILL;
                            end else if (r_retry >= r_retry_limit) begin
                                n_phase        = PH_IDLE;
                                n_out.done_res = 1'b1;
                                n_out.status   = sdspi_pkg::ST_RST_TMO;
                            end else begin
                                n_phase = PH_DUMMY;
                                n_out.tx_valid = 1'b1;
                                n_out.tx_byte  = FILL;
                            end
                        end
                        PH_CMD1_TRAIL: begin
                            n_phase = PH_DUMMY;
                            n_out.tx_valid = 1'b1;
                            n_out.tx_byte  = FILL;
                        end
                        PH_TOKEN: begin
                            n_poll = w_poll_inc;
                            if (i_in.rx_byte == TOKEN) begin
                                n_phase    = PH_DATA;
                                n_byte_cnt = '0;
                                n_out.tx_valid = 1'b1;
                                n_out.tx_byte  = FILL;
                            end else if (w_poll_inc >= r_token_limit) begin
                                n_sel          = 1'b0;
                                n_phase        = PH_IDLE;
                                n_out.done_res = 1'b1;
                                n_out.status   = sdspi_pkg::ST_NO_TOKEN;
                            end else begin
                                n_out.tx_valid = 1'b1;
                                n_out.tx_byte  = FILL;
                            end
                        end
                        PH_DATA: begin
                            n_out.data_valid = 1'b1;
                            n_out.data_byte  = i_in.rx_byte;
                            n_out.tx_valid   = 1'b1;
                            n_out.tx_byte    = FILL;
                            n_byte_cnt       = w_bc_inc;
                            if (w_bc_inc >= BLOCK_LEN) begin
                                n_out.last_data = 1'b1;
                                n_phase         = PH_CRC;
                                n_byte_cnt      = '0;
                            end
                        end
                        PH_CRC: begin
                            n_byte_cnt = w_bc_inc;
                            if (w_bc_inc < BC_W'(2)) begin
                                n_out.tx_valid = 1'b1;
                                n_out.tx_byte  = FILL;
                            end else begin
                                n_sel          = 1'b0;
                                n_phase        = PH_IDLE;
                                n_out.done_res = 1'b1;
                                n_out.status   = sdspi_pkg::ST_OK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        n_out.cs_active  = n_sel;
        n_out.fast_clock = n_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_cnt    <= 8'd10;
            r_retry_limit <= 8'd16;
            r_poll_limit  <= 8'd128;
            r_token_limit <= 8'd255;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                sdspi_pkg::CFG_WAKE_CNT:    r_wake_cnt    <= i_cfg.wdata;
                sdspi_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg.wdata;
                sdspi_pkg::CFG_POLL_LIMIT:  r_poll_limit  <= i_cfg.wdata;
                sdspi_pkg::CFG_TOKEN_LIMIT: r_token_limit <= i_cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_byte_cnt  <= '0;
            r_retry     <= '0;
            r_poll      <= '0;
            r_frame_idx <= '0;
            r_cmd_op    <= '0;
            r_cmd_addr  <= '0;
            r_crc_set   <= 1'b0;
            r_last_resp <= FILL;
            r_speed     <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_byte_cnt  <= n_byte_cnt;
            r_retry     <= n_retry;
            r_poll      <= n_poll;
            r_frame_idx <= n_frame_idx;
            r_cmd_op    <= n_cmd_op;
            r_cmd_addr  <= n_cmd_addr;
            r_crc_set   <= n_crc_set;
            r_last_resp <= n_last_resp;
            r_speed     <= n_speed;
            r_sel       <= n_sel;
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only on a request transaction
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.tx_valid   = r_out.tx_valid;
    assign o_out.tx_byte    = r_out.tx_byte;
    assign o_out.cs_active  = r_out.cs_active;
    assign o_out.fast_clock = r_out.fast_clock;
    assign o_out.data_valid = r_out.data_valid;
    assign o_out.data_byte  = r_out.data_byte;
    assign o_out.last_data  = r_out.last_data;
    assign o_out.done_res   = r_out.done_res;
    assign o_out.status     = r_out.status;

    `SDSPI_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, w_in_acc, r_out_valid)
    `SDSPI_ASSERT_IMP(a_idle_byte_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.tx_valid, r_out.tx_byte == 8'h00)
    `SDSPI_ASSERT_IMP(a_data_fast, i_clk, i_rst_n,
        r_out_valid && r_out.data_valid, r_out.fast_clock && r_out.cs_active)
    `SDSPI_ASSERT_IMP(a_last_is_data, i_clk, i_rst_n,
        r_out_valid && r_out.last_data, r_out.data_valid)
    `SDSPI_ASSERT_IMP(a_frame_idx_range, i_clk, i_rst_n,
        r_phase == PH_FRAME, r_frame_idx < FRAME_LEN)

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking bench for the SPI-mode card sequencer: init, block read, register writes.
// Depends on sdspi_pkg, the channel interfaces and sd_spi_init_and_block_read.
// A card responder shapes the received bytes from the tracked sequencer phase.
`default_nettype none
module testbench;
    import sdspi_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int STALL_CYCLES = 400;
    localparam int RANDOM_ITEMS = 700;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    localparam logic [7:0] OPC_CMD0    = 8'h40;
    localparam logic [7:0] OPC_CMD1    = 8'h41;
    localparam logic [7:0] OPC_CMD17   = 8'h51;
    localparam logic [7:0] CMD0_CRC    = 8'h95;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] START_TOKEN = 8'hFE;
    localparam logic [7:0] R1_READY    = 8'h00;
    localparam logic [7:0] R1_IDLE     = 8'h01;
    localparam logic [7:0] R1_ILLEGAL  = 8'h04;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_WAKE, SEQ_DUMMY, SEQ_FRAME, SEQ_POLL,
        SEQ_CMD0_TAIL, SEQ_CMD1_TAIL, SEQ_TOKEN, SEQ_DATA, SEQ_CRC
    } seq_phase_e;

    // Tracks the sequencer state and holds the replies still owed by the block.
    class reply_tracker;
        t_result    replies_due[$];
        int         errors;
        logic [7:0] wake_cnt, retry_lim, poll_lim, token_lim;
        seq_phase_e phase;
        logic [15:0] byte_cnt;
        logic [7:0] retry_cnt, poll_cnt;
        logic [2:0] frame_idx;
        logic [7:0] cmd_frame [6];
        logic [7:0] last_resp;
        logic       speed, sel;
        t_result    reply;

        function new();
            wake_cnt    = 8'd10;
            retry_lim   = 8'd16;
            poll_lim    = 8'd128;
            token_lim   = 8'd255;
            phase       = SEQ_IDLE;
            byte_cnt    = '0;
            retry_cnt   = '0;
            poll_cnt    = '0;
            frame_idx   = '0;
            foreach (cmd_frame[i]) cmd_frame[i] = '0;
            last_resp   = 8'hFF;
            speed       = 1'b0;
            sel         = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_WAKE_CNT:    wake_cnt  = val;
                CFG_RETRY_LIMIT: retry_lim = val;
                CFG_POLL_LIMIT:  poll_lim  = val;
                CFG_TOKEN_LIMIT: token_lim = val;
                default: ;
            endcase
        endfunction

        function void emit(logic [7:0] b);
            reply.tx_valid = 1'b1;
            reply.tx_byte  = b;
        endfunction

        function void complete(logic [STATUS_W-1:0] st);
            phase          = SEQ_IDLE;
            reply.done_res = 1'b1;
            reply.status   = st;
        endfunction

        function void open_exchange();
            phase = SEQ_DUMMY;
            emit(IDLE_BYTE);
        endfunction

        function void take_request(logic [FUNC_W-1:0] fn, logic [BLK_W-1:0] blk,
                                   logic [7:0] rx);
            logic [23:0] addr;
            reply = '0;
            addr  = {blk, 1'b0};
            case (fn)
                FUNC_INIT: begin
                    speed        = 1'b0;
                    sel          = 1'b0;
                    cmd_frame[0] = OPC_CMD0;
                    cmd_frame[1] = 8'h00;
                    cmd_frame[2] = 8'h00;
                    cmd_frame[3] = 8'h00;
                    cmd_frame[4] = 8'h00;
                    cmd_frame[5] = CMD0_CRC;
                    retry_cnt    = '0;
                    if (wake_cnt == 8'd0) begin
                        open_exchange();
                    end else begin
                        phase    = SEQ_WAKE;
                        byte_cnt = 16'd1;
                        emit(IDLE_BYTE);
                    end
                end
                FUNC_READ: begin
                    speed        = 1'b1;
                    cmd_frame[0] = OPC_CMD17;
                    cmd_frame[1] = addr[23:16];
                    cmd_frame[2] = addr[15:8];
                    cmd_frame[3] = addr[7:0];
                    cmd_frame[4] = 8'h00;
                    open_exchange();
                end
                FUNC_XFER: begin
                    case (phase)
                        SEQ_WAKE: begin
                            if (byte_cnt >= {8'h00, wake_cnt}) begin
                                open_exchange();
                            end else begin
                                byte_cnt++;
                                emit(IDLE_BYTE);
                            end
                        end
                        SEQ_DUMMY: begin
                            sel       = 1'b1;
                            frame_idx = '0;
                            phase     = SEQ_FRAME;
                            emit(cmd_frame[0]);
                        end
                        SEQ_FRAME: begin
                            frame_idx++;
                            if (frame_idx < 3'd6) begin
                                emit(cmd_frame[frame_idx]);
                            end else begin
                                phase    = SEQ_POLL;
                                poll_cnt = '0;
                                emit(IDLE_BYTE);
                            end
                        end
                        SEQ_POLL: begin
                            if (poll_cnt != 8'hFF) poll_cnt++;
                            if (!rx[7] || poll_cnt >= poll_lim) begin
                                last_resp = rx;
                                if (cmd_frame[0] == OPC_CMD0) begin
                                    if (retry_cnt != 8'hFF) retry_cnt++;
                                    sel   = 1'b0;
                                    phase = SEQ_CMD0_TAIL;
                                    emit(IDLE_BYTE);
                                end else if (cmd_frame[0] == OPC_CMD1) begin
                                    if (rx == R1_READY) begin
                                        complete(ST_OK);
                                    end else begin
                                        sel   = 1'b0;
                                        phase = SEQ_CMD1_TAIL;
                                        emit(IDLE_BYTE);
                                    end
                                end else if (rx != R1_READY) begin
                                    sel = 1'b0;
                                    complete(ST_CMD_ERR);
                                end else begin
                                    phase    = SEQ_TOKEN;
                                    poll_cnt = '0;
                                    emit(IDLE_BYTE);
                                end
                            end else begin
                                emit(IDLE_BYTE);
                            end
                        end
                        SEQ_CMD0_TAIL: begin
                            if (last_resp == R1_IDLE) begin
                                cmd_frame[0] = OPC_CMD1;
                                open_exchange();
                            end else if (retry_cnt >= retry_lim) begin
                                complete(ST_RST_TMO);
                            end else begin
                                open_exchange();
                            end
                        end
                        SEQ_CMD1_TAIL: open_exchange();
                        SEQ_TOKEN: begin
                            if (poll_cnt != 8'hFF) poll_cnt++;
                            if (rx == START_TOKEN) begin
                                phase    = SEQ_DATA;
                                byte_cnt = '0;
                                emit(IDLE_BYTE);
                            end else if (poll_cnt >= token_lim) begin
                                sel = 1'b0;
                                complete(ST_NO_TOKEN);
                            end else begin
                                emit(IDLE_BYTE);
                            end
                        end
                        SEQ_DATA: begin
                            reply.data_valid = 1'b1;
                            reply.data_byte  = rx;
                            byte_cnt++;
                            if (byte_cnt >= 16'(BLOCK_BYTES)) begin
                                reply.last_data = 1'b1;
                                phase           = SEQ_CRC;
                                byte_cnt        = '0;
                            end
                            emit(IDLE_BYTE);
                        end
                        SEQ_CRC: begin
                            byte_cnt++;
                            if (byte_cnt < 16'd2) begin
                                emit(IDLE_BYTE);
                            end else begin
                                sel = 1'b0;
                                complete(ST_OK);
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            reply.cs_active  = sel;
            reply.fast_clock = speed;
            replies_due.push_back(reply);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void compare_reply(t_result got);
            t_result want;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result, none pending, got %h", $time, got);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            check_field("tx_valid",   8'(want.tx_valid),   8'(got.tx_valid));
            check_field("tx_byte",    want.tx_byte,        got.tx_byte);
            check_field("cs_active",  8'(want.cs_active),  8'(got.cs_active));
            check_field("fast_clock", 8'(want.fast_clock), 8'(got.fast_clock));
            check_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
            check_field("data_byte",  want.data_byte,      got.data_byte);
            check_field("last_data",  8'(want.last_data),  8'(got.last_data));
            check_field("done_res",   8'(want.done_res),   8'(got.done_res));
            check_field("status",     8'(want.status),     8'(got.status));
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sdspi_in_if  in_ch ();
    sdspi_out_if out_ch ();
    sdspi_cfg_if cfg_ch ();

    sd_spi_init_and_block_read dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    reply_tracker tracker = new();

    bit calm        = 1'b0;
    bit stall_req   = 1'b0;
    bit stall_taken = 1'b0;
    bit stall_done  = 1'b0;
    bit no_token    = 1'b0;
    int stall_left  = 0;
    int stim_items  = 0;
    int cycle_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (stall_req && !stall_taken) begin
            stall_taken = 1'b1;
            stall_left  = STALL_CYCLES;
        end
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.tx_valid   = out_ch.tx_valid;
                got.tx_byte    = out_ch.tx_byte;
                got.cs_active  = out_ch.cs_active;
                got.fast_clock = out_ch.fast_clock;
                got.data_valid = out_ch.data_valid;
                got.data_byte  = out_ch.data_byte;
                got.last_data  = out_ch.last_data;
                got.done_res   = out_ch.done_res;
                got.status     = out_ch.status;
                tracker.compare_reply(got);
            end
            if (cfg_ch.valid && cfg_ch.ready)
                tracker.write_reg(cfg_ch.reg_index, cfg_ch.wdata);
            if (in_ch.valid && in_ch.ready)
                tracker.take_request(in_ch.func, in_ch.block_addr, in_ch.rx_byte);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [BLK_W-1:0] blk,
                             input logic [7:0] rx);
        while (!calm && $urandom_range(99) < 37) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= fn;
        in_ch.block_addr <= blk;
        in_ch.rx_byte    <= rx;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (tracker.replies_due.size() != 0) @(negedge i_clk);
    endtask

    // leaves valid high so that writes can follow back to back
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_limits(input logic [7:0] wake, input logic [7:0] retry,
                                  input logic [7:0] poll, input logic [7:0] token);
        wait_for_results();
        write_register(CFG_WAKE_CNT, wake);
        write_register(CFG_RETRY_LIMIT, retry);
        write_register(CFG_POLL_LIMIT, poll);
        write_register(CFG_TOKEN_LIMIT, token);
        cfg_ch.valid <= 1'b0;
    endtask

    // what the card puts on the line, given where the sequencer stands
    function automatic logic [7:0] card_byte();
        logic [7:0] b;
        b = 8'($urandom);
        case (tracker.phase)
            SEQ_POLL: begin
                if ($urandom_range(99) < 60)
                    b[7] = 1'b1;
                else if (tracker.cmd_frame[0] == OPC_CMD0)
                    b = ($urandom_range(99) < 75) ? R1_IDLE : {1'b0, b[6:0]};
                else if (tracker.cmd_frame[0] == OPC_CMD1)
                    b = ($urandom_range(1) == 0) ? R1_READY : R1_IDLE;
                else if ($urandom_range(99) < 85)
                    b = R1_READY;
                else
                    b = {1'b0, b[6:0]};
            end
            SEQ_TOKEN: begin
                if (no_token) begin
                    if (b == START_TOKEN) b = IDLE_BYTE;
                end else if ($urandom_range(99) < 30) begin
                    b = START_TOKEN;
                end
            end
            default: ;
        endcase
        return b;
    endfunction

    task automatic run_operation(input bit rd);
        int pick;
        no_token = ($urandom_range(9) == 0);
        send_item(rd ? FUNC_READ : FUNC_INIT, BLK_W'($urandom), 8'($urandom));
        stim_items++;
        while (tracker.phase != SEQ_IDLE && stim_items < RANDOM_ITEMS) begin
            calm = (stim_items >= 250 && stim_items < 400);
            if (!stall_done && stim_items >= 100) begin
                stall_req  = 1'b1;
                stall_done = 1'b1;
            end
            pick = $urandom_range(999);
            if (pick < 10) begin
                send_item(FUNC_NONE, BLK_W'($urandom), 8'($urandom));
            end else begin
                // no restarts inside a data block, so that whole blocks get through
                if (pick < 13 && tracker.phase != SEQ_DATA)
                    send_item(($urandom_range(1) == 0) ? FUNC_READ : FUNC_INIT,
                              BLK_W'($urandom), 8'($urandom));
                else
                    send_item(FUNC_XFER, BLK_W'($urandom), card_byte());
                stim_items++;
            end
        end
        // exchange with nothing running
        if (tracker.phase == SEQ_IDLE && $urandom_range(7) == 0)
            send_item(FUNC_XFER, BLK_W'($urandom), 8'($urandom));
    endtask

    initial begin
        int ops;
        in_ch.valid      = 1'b0;
        in_ch.func       = FUNC_INIT;
        in_ch.block_addr = '0;
        in_ch.rx_byte    = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = CFG_WAKE_CNT;
        cfg_ch.wdata     = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // read before any init, highest block, card rejects the command
        send_item(FUNC_READ, 23'h7FFFFF, 8'h00);
        send_item(FUNC_XFER, 23'h000000, 8'h00);
        repeat (6) send_item(FUNC_XFER, 23'h7FFFFF, IDLE_BYTE);
        send_item(FUNC_XFER, 23'h000000, R1_ILLEGAL);
        send_item(FUNC_XFER, 23'h2AAAAA, 8'hAA);
        send_item(FUNC_NONE, 23'h555555, 8'h55);

        // zero limits (wake count apart) behave as one; unused index is ignored
        wait_for_results();
        write_register(8'hFF, 8'h5A);
        program_limits(8'd0, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_INIT, 23'h000000, IDLE_BYTE);
        repeat (3) send_item(FUNC_XFER, 23'h000000, IDLE_BYTE);
        // restart as a read while the init is mid-frame
        send_item(FUNC_READ, 23'h400001, 8'h00);
        repeat (7) send_item(FUNC_XFER, 23'h000000, 8'h00);
        send_item(FUNC_XFER, 23'h000000, R1_READY);
        send_item(FUNC_XFER, 23'h000000, 8'h00);

        ops = 0;
        while (stim_items < RANDOM_ITEMS) begin
            if (ops % 4 == 0) begin
                case ((ops / 4) % 4)
                    0: program_limits(8'd10, 8'd16, 8'd128, 8'd255);
                    1: program_limits(8'd1, 8'd1, 8'd1, 8'd1);
                    2: program_limits(8'($urandom_range(12, 1)), 8'($urandom_range(6, 1)),
                                      8'($urandom_range(16, 1)), 8'($urandom_range(40, 1)));
                    default: program_limits(8'd255, 8'd255, 8'd255, 8'd255);
                endcase
            end
            run_operation($urandom_range(99) < 55);
            ops++;
        end
        calm = 1'b0;

        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.replies_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
